@@ src/dsaa_pkg.sv @@
// shared constants, types and the address to slot mapping for the slot allocator
// no dependencies
package dsaa_pkg;

  localparam int SLOTS  = 256;
  localparam int SLOT_W = $clog2(SLOTS);
  localparam int CNT_W  = $clog2(SLOTS + 1);
  localparam int SCAN_W = SLOT_W + 1;
  localparam int POOL_N_W = $clog2(SLOTS + 2);
  localparam int ID_W   = 32;
  localparam int ADDR_W = 32;
  localparam int CFG_AW = 3;

  localparam logic [CFG_AW-1:0] REG_BASE_LOW = CFG_AW'(0);

  typedef enum logic [2:0] {
    OP_ASSIGN_NEXT   = 3'd0,
    OP_ASSIGN_STATIC = 3'd1,
    OP_RELEASE       = 3'd2,
    OP_LOOKUP        = 3'd3,
    OP_ID_TO_ADDR    = 3'd4,
    OP_NEXT_DEV      = 3'd5
  } op_t;

  // bytewise difference from the base, out of range maps to slot 0
  function automatic logic [SLOT_W-1:0] slot_of(input logic [ADDR_W-1:0] addr,
                                                input logic [ADDR_W-1:0] base);
    logic [ADDR_W-1:0] r;
    r[31:24] = addr[31:24] - base[31:24];
    r[23:16] = addr[23:16] - base[23:16];
    r[15:8]  = addr[15:8]  - base[15:8];
    r[7:0]   = addr[7:0]   - base[7:0];
    return (r >= ADDR_W'(SLOTS)) ? '0 : r[SLOT_W-1:0];
  endfunction

endpackage

@@ src/dsaa_id_ram.sv @@
// device identifier store, one write and one registered read port
// depends on dsaa_pkg
module dsaa_id_ram (
  input  logic                        clk,
  input  logic                        we,
  input  logic [dsaa_pkg::SLOT_W-1:0] waddr,
  input  logic [dsaa_pkg::ID_W-1:0]   wdata,
  input  logic [dsaa_pkg::SLOT_W-1:0] raddr,
  output logic [dsaa_pkg::ID_W-1:0]   rdata
);
  import dsaa_pkg::*;

  logic [ID_W-1:0] mem [SLOTS];
  logic [ID_W-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;

endmodule

@@ src/device_slot_address_allocator.sv @@
// Slot allocator for device addresses in a subnet: one word in, one result word out. Lookup
// and release read at most one stored identifier; an identifier search scans the slot table,
// the next-free and next-device walks step through the slot marks, and an assignment whose
// slot number is already held as an identifier runs up to (SLOTS+2) full scans of the table;
// these scans are paced by the single read port of the identifier store, one compare at a time.
// Input stalls while a word is in progress; a finished result waits in the output register.
// depends on dsaa_pkg and dsaa_id_ram
module device_slot_address_allocator (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        in_valid,
  output logic                        in_stall,
  input  logic [2:0]                  in_operation,
  input  logic [dsaa_pkg::ADDR_W-1:0] in_address_low,
  input  logic [dsaa_pkg::ID_W-1:0]   in_device_id_in,
  output logic                        out_valid,
  input  logic                        out_stall,
  output logic                        out_status,
  output logic                        out_found,
  output logic [dsaa_pkg::ADDR_W-1:0] out_address_out,
  output logic [dsaa_pkg::ID_W-1:0]   out_device_id_out,
  output logic [dsaa_pkg::CNT_W-1:0]  out_device_count,
  input  logic                        cfg_psel,
  input  logic                        cfg_penable,
  input  logic                        cfg_pwrite,
  input  logic [dsaa_pkg::CFG_AW-1:0] cfg_paddr,
  input  logic [31:0]                 cfg_pwdata,
  output logic [31:0]                 cfg_prdata,
  output logic                        cfg_pready
);
  import dsaa_pkg::*;

  typedef enum logic [3:0] {
    S_IDLE, S_DECODE, S_PTR, S_CHECK, S_HELD_RD, S_HELD_CMP, S_HELD, S_NOT_HELD,
    S_WRITE, S_FIND_RD, S_FIND_CMP, S_NEXT, S_RD, S_RDDONE, S_OUT
  } state_t;

  state_t               state_r;
  logic [ADDR_W-1:0]    base_low_r;
  logic [SLOTS-1:0]     used_r;
  logic [CNT_W-1:0]     cnt_r;
  logic [SLOT_W-1:0]    alloc_ptr_r;
  logic [ID_W-1:0]      id_pool_r;
  op_t                  op_r;
  logic [ADDR_W-1:0]    addr_r;
  logic [ID_W-1:0]      idin_r;
  logic [SLOT_W-1:0]    slot_r;
  logic [SLOT_W-1:0]    ptr_r;
  logic [SCAN_W-1:0]    scan_r;
  logic                 phase_r;
  logic [ID_W-1:0]      pool_r;
  logic [POOL_N_W-1:0]  n_r;
  logic [ID_W-1:0]      new_id_r;
  logic                 st_r;
  logic                 found_r;
  logic [ADDR_W-1:0]    aout_r;
  logic [ID_W-1:0]      idout_r;
  logic                 out_valid_r;
  logic                 o_status_r;
  logic                 o_found_r;
  logic [ADDR_W-1:0]    o_aout_r;
  logic [ID_W-1:0]      o_idout_r;
  logic [CNT_W-1:0]     o_cnt_r;

  logic [SLOT_W-1:0]    slot_c;
  logic                 ptr_skip;
  logic                 scan_last;
  logic [SLOT_W-1:0]    scan_slot;
  logic [ID_W-1:0]      held_key;
  logic [ID_W-1:0]      rd_data;
  logic [SLOT_W-1:0]    rd_addr;
  logic                 id_we;
  logic                 full;
  logic                 cfg_wr;

  assign slot_c    = slot_of(addr_r, base_low_r);
  assign ptr_skip  = used_r[ptr_r] || (ptr_r < SLOT_W'(2)) || (ptr_r == SLOT_W'(SLOTS - 1));
  assign scan_last = (scan_r == SCAN_W'(SLOTS));
  assign scan_slot = scan_r[SLOT_W-1:0];
  assign held_key  = phase_r ? pool_r : ID_W'(slot_r);
  assign rd_addr   = (state_r == S_RD) ? slot_r : scan_slot;
  assign id_we     = (state_r == S_WRITE);
  assign full      = (cnt_r >= CNT_W'(SLOTS - 3));
  assign cfg_wr    = cfg_psel && cfg_penable && cfg_pwrite && cfg_pready;

  dsaa_id_ram u_id_ram (
    .clk   (clk),
    .we    (id_we),
    .waddr (slot_r),
    .wdata (new_id_r),
    .raddr (rd_addr),
    .rdata (rd_data)
  );

  assign cfg_pready = 1'b1;
  assign cfg_prdata = (cfg_paddr == REG_BASE_LOW) ? base_low_r : '0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      base_low_r <= '0;
    end else if (cfg_wr && (cfg_paddr == REG_BASE_LOW)) begin
      base_low_r <= cfg_pwdata;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      used_r      <= '0;
      cnt_r       <= '0;
      alloc_ptr_r <= '0;
      id_pool_r   <= ID_W'(1);
      out_valid_r <= 1'b0;
    end else begin
      if (out_valid_r && !out_stall && state_r != S_OUT) begin
        out_valid_r <= 1'b0;
      end
      unique case (state_r)
        S_IDLE: begin
          if (in_valid) begin
            op_r    <= op_t'(in_operation);
            addr_r  <= in_address_low;
            idin_r  <= in_device_id_in;
            state_r <= S_DECODE;
          end
        end
        S_DECODE: begin
          slot_r  <= slot_c;
          idout_r <= '0;
          unique case (op_r)
            OP_ASSIGN_NEXT: begin
              ptr_r   <= alloc_ptr_r;
              aout_r  <= addr_r;
              found_r <= 1'b0;
              st_r    <= 1'b1;
              state_r <= full ? S_OUT : S_PTR;
            end
            OP_ASSIGN_STATIC: begin
              aout_r  <= addr_r;
              found_r <= 1'b0;
              st_r    <= 1'b1;
              state_r <= S_CHECK;
            end
            OP_RELEASE: begin
              aout_r  <= addr_r;
              found_r <= used_r[slot_c];
              if (cnt_r >= CNT_W'(2) && slot_c >= SLOT_W'(2) && used_r[slot_c]) begin
                used_r[slot_c] <= 1'b0;
                cnt_r          <= cnt_r - CNT_W'(1);
                st_r           <= 1'b0;
              end else begin
                st_r           <= 1'b1;
              end
              state_r <= used_r[slot_c] ? S_RD : S_OUT;
            end
            OP_LOOKUP: begin
              aout_r  <= addr_r;
              found_r <= used_r[slot_c];
              st_r    <= !used_r[slot_c];
              state_r <= used_r[slot_c] ? S_RD : S_OUT;
            end
            OP_ID_TO_ADDR: begin
              scan_r  <= '0;
              aout_r  <= base_low_r | ADDR_W'(idin_r[7:0]);
              found_r <= 1'b0;
              st_r    <= 1'b1;
              state_r <= S_FIND_RD;
            end
            OP_NEXT_DEV: begin
              scan_r  <= SCAN_W'(slot_c) + SCAN_W'(1);
              aout_r  <= addr_r;
              found_r <= 1'b0;
              st_r    <= 1'b1;
              state_r <= S_NEXT;
            end
            default: begin
              aout_r  <= addr_r;
              found_r <= 1'b0;
              st_r    <= 1'b1;
              state_r <= S_OUT;
            end
          endcase
        end
        S_PTR: begin
          if (ptr_skip) begin
            ptr_r <= (ptr_r == SLOT_W'(SLOTS - 1)) ? '0 : ptr_r + SLOT_W'(1);
          end else begin
            alloc_ptr_r <= ptr_r;
            addr_r      <= base_low_r | ADDR_W'(ptr_r);
            aout_r      <= base_low_r | ADDR_W'(ptr_r);
            state_r     <= S_CHECK;
          end
        end
        S_CHECK: begin
          slot_r <= slot_c;
          if (full || slot_c == '0 || slot_c == SLOT_W'(SLOTS - 1) || used_r[slot_c]) begin
            found_r <= used_r[slot_c];
            state_r <= used_r[slot_c] ? S_RD : S_OUT;
          end else begin
            scan_r  <= '0;
            phase_r <= 1'b0;
            state_r <= S_HELD_RD;
          end
        end
        S_HELD_RD: begin
          if (scan_last) begin
            state_r <= S_NOT_HELD;
          end else if (scan_slot != slot_r && used_r[scan_slot]) begin
            state_r <= S_HELD_CMP;
          end else begin
            scan_r <= scan_r + SCAN_W'(1);
          end
        end
        S_HELD_CMP: begin
          if (rd_data == held_key) begin
            state_r <= S_HELD;
          end else begin
            scan_r  <= scan_r + SCAN_W'(1);
            state_r <= S_HELD_RD;
          end
        end
        S_HELD: begin
          scan_r <= '0;
          if (!phase_r) begin
            phase_r <= 1'b1;
            pool_r  <= id_pool_r;
            n_r     <= '0;
            state_r <= S_HELD_RD;
          end else begin
            pool_r <= pool_r + ID_W'(1);
            n_r    <= n_r + POOL_N_W'(1);
            if (n_r < POOL_N_W'(SLOTS)) begin
              state_r <= S_HELD_RD;
            end else begin
              new_id_r  <= pool_r + ID_W'(1);
              id_pool_r <= pool_r + ID_W'(2);
              state_r   <= S_WRITE;
            end
          end
        end
        S_NOT_HELD: begin
          new_id_r <= held_key;
          if (phase_r) begin
            id_pool_r <= pool_r + ID_W'(1);
          end
          state_r <= S_WRITE;
        end
        S_WRITE: begin
          used_r[slot_r] <= 1'b1;
          cnt_r          <= cnt_r + CNT_W'(1);
          st_r           <= 1'b0;
          found_r        <= 1'b1;
          idout_r        <= new_id_r;
          state_r        <= S_OUT;
        end
        S_FIND_RD: begin
          if (scan_last) begin
            state_r <= S_OUT;
          end else if (used_r[scan_slot]) begin
            state_r <= S_FIND_CMP;
          end else begin
            scan_r <= scan_r + SCAN_W'(1);
          end
        end
        S_FIND_CMP: begin
          if (rd_data == idin_r) begin
            aout_r  <= base_low_r | ADDR_W'(scan_slot);
            found_r <= 1'b1;
            st_r    <= 1'b0;
            idout_r <= idin_r;
            state_r <= S_OUT;
          end else begin
            scan_r  <= scan_r + SCAN_W'(1);
            state_r <= S_FIND_RD;
          end
        end
        S_NEXT: begin
          if (scan_last) begin
            state_r <= S_OUT;
          end else if (scan_slot >= SLOT_W'(2) && used_r[scan_slot]) begin
            aout_r  <= base_low_r | ADDR_W'(scan_slot);
            found_r <= 1'b1;
            st_r    <= 1'b0;
            slot_r  <= scan_slot;
            state_r <= S_RD;
          end else begin
            scan_r <= scan_r + SCAN_W'(1);
          end
        end
        S_RD: state_r <= S_RDDONE;
        S_RDDONE: begin
          idout_r <= rd_data;
          state_r <= S_OUT;
        end
        S_OUT: begin
          if (!out_valid_r || !out_stall) begin
            out_valid_r <= 1'b1;
            o_status_r  <= st_r;
            o_found_r   <= found_r;
            o_aout_r    <= aout_r;
            o_idout_r   <= idout_r;
            o_cnt_r     <= cnt_r;
            state_r     <= S_IDLE;
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  assign in_stall          = (state_r != S_IDLE);
  assign out_valid         = out_valid_r;
  assign out_status        = o_status_r;
  assign out_found         = o_found_r;
  assign out_address_out   = o_aout_r;
  assign out_device_id_out = o_idout_r;
  assign out_device_count  = o_cnt_r;

`ifndef SYNTHESIS
  a_count_matches: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r == CNT_W'($countones(used_r)))
    else $error("occupied count out of step with slot marks");
  a_reserved_free: assert property (@(posedge clk) disable iff (!rst_n)
    !used_r[0] && !used_r[SLOTS-1])
    else $error("reserved slot marked occupied");
  a_write_free: assert property (@(posedge clk) disable iff (!rst_n)
    id_we |-> !used_r[slot_r])
    else $error("identifier written into occupied slot");
  a_out_from_fsm: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(state_r == S_OUT))
    else $error("result word raised outside output state");
`endif

endmodule

@@ verif/tb_top.sv @@
// Self-checking bench for the device slot address allocator: random and directed
// words with a built-in model of the slot table, checked result by result.
// Depends on dsaa_pkg and device_slot_address_allocator.
`timescale 1ns / 100ps

module tb_top;
  import dsaa_pkg::*;

  localparam logic [2:0] OP_UNUSED_A = 3'd6;
  localparam logic [2:0] OP_UNUSED_B = 3'd7;
  localparam longint CYCLE_LIMIT = 20000000;

  typedef struct {
    logic [2:0]  op;
    logic [31:0] addr;
    logic [31:0] id;
  } request_t;

  typedef struct {
    logic        status;
    logic        found;
    logic [31:0] addr;
    logic [31:0] id;
    logic [8:0]  count;
  } reply_t;

  logic clk = 0;
  logic rst_n = 0;
  logic in_valid = 0, in_stall;
  logic [2:0] in_operation = '0;
  logic [31:0] in_address_low = '0, in_device_id_in = '0;
  logic out_valid, out_stall = 0, out_status, out_found;
  logic [31:0] out_address_out, out_device_id_out;
  logic [CNT_W-1:0] out_device_count;
  logic cfg_psel = 0, cfg_penable = 0, cfg_pwrite = 0, cfg_pready;
  logic [CFG_AW-1:0] cfg_paddr = '0;
  logic [31:0] cfg_pwdata = '0, cfg_prdata;

  device_slot_address_allocator dut (.*);

  // model state
  logic [31:0] base_reg = '0;
  logic        occupied[SLOTS];
  logic [31:0] slot_ident[SLOTS];
  logic [7:0]  next_ptr = '0;
  logic [31:0] pool_next = 1;
  int          held = 0;

  request_t pending[$];
  reply_t   replies_due[$];
  longint   cyc = 0;
  bit       failed = 0;
  int       issued = 0;
  int       checked = 0;

  initial forever #5 clk = ~clk;

  function automatic int slot_from(logic [31:0] a);
    logic [31:0] d;
    for (int b = 0; b < 4; b++) d[8*b +: 8] = a[8*b +: 8] - base_reg[8*b +: 8];
    return (d >= SLOTS) ? 0 : int'(d);
  endfunction

  function automatic bit id_taken(logic [31:0] idv, int skip);
    if (held == 0) return 0;
    for (int i = 0; i < SLOTS; i++)
      if (i != skip && occupied[i] && slot_ident[i] == idv) return 1;
    return 0;
  endfunction

  function automatic bit claim_slot(logic [31:0] a, output int s);
    logic [31:0] p;
    s = slot_from(a);
    if (held >= SLOTS - 3 || s < 1 || s == SLOTS - 1) return 0;
    if (held != 0 && occupied[s]) return 0;
    if (!id_taken(32'(s), s)) slot_ident[s] = 32'(s);
    else begin
      p = pool_next;
      for (int n = 0; n <= SLOTS && id_taken(p, s); n++) p++;
      slot_ident[s] = p;
      pool_next = p + 32'd1;
    end
    occupied[s] = 1;
    held++;
    return 1;
  endfunction

  function automatic reply_t predict_reply(request_t rq);
    reply_t r;
    int s, p;
    logic [31:0] a;
    a = rq.addr;
    r = '{1'b1, 1'b0, rq.addr, 32'd0, 9'd0};
    case (rq.op)
      OP_ASSIGN_NEXT, OP_ASSIGN_STATIC: begin
        if (rq.op == OP_ASSIGN_NEXT) begin
          if (held >= SLOTS - 3) begin
            r.count = 9'(held);
            return r;
          end
          p = int'(next_ptr);
          for (int n = 0; n < SLOTS && (occupied[p] || p < 2 || p == SLOTS - 1); n++)
            p = (p + 1) % SLOTS;
          next_ptr = 8'(p);
          a = base_reg | 32'(p);
          r.addr = a;
        end
        r.status = !claim_slot(a, s);
        if (occupied[s]) begin
          r.found = 1;
          r.id = slot_ident[s];
        end
      end
      OP_RELEASE: begin
        s = slot_from(a);
        if (occupied[s]) begin
          r.found = 1;
          r.id = slot_ident[s];
        end
        if (held >= 2 && s >= 2 && occupied[s]) begin
          occupied[s] = 0;
          held--;
          r.status = 0;
        end
      end
      OP_LOOKUP: begin
        s = slot_from(a);
        if (held != 0 && occupied[s]) begin
          r.found = 1;
          r.status = 0;
          r.id = slot_ident[s];
        end
      end
      OP_ID_TO_ADDR: begin
        r.addr = base_reg | {24'd0, rq.id[7:0]};
        for (int i = 0; i < SLOTS; i++)
          if (occupied[i] && slot_ident[i] == rq.id) begin
            r.addr = base_reg | 32'(i);
            r.found = 1;
            r.status = 0;
            r.id = rq.id;
            break;
          end
      end
      OP_NEXT_DEV: begin
        s = slot_from(a);
        for (int i = s + 1; i < SLOTS; i++)
          if (i >= 2 && occupied[i]) begin
            r.addr = base_reg | 32'(i);
            r.found = 1;
            r.status = 0;
            r.id = slot_ident[i];
            break;
          end
      end
      default: ;
    endcase
    r.count = 9'(held);
    return r;
  endfunction

  function automatic logic [31:0] slot_addr(int s);
    return {base_reg[31:8], base_reg[7:0] + 8'(s)};
  endfunction

  function automatic request_t make_request(int assign_pct);
    request_t rq;
    int r;
    r = $urandom_range(99);
    if (r < assign_pct) rq.op = $urandom_range(1) ? OP_ASSIGN_NEXT : OP_ASSIGN_STATIC;
    else if (r < 97) rq.op = 3'($urandom_range(int'(OP_RELEASE), int'(OP_NEXT_DEV)));
    else rq.op = $urandom_range(1) ? OP_UNUSED_A : OP_UNUSED_B;
    rq.addr = ($urandom_range(99) < 85) ? slot_addr($urandom_range(SLOTS - 1)) : $urandom;
    rq.id = ($urandom_range(99) < 70) ? 32'($urandom_range(300)) : $urandom;
    return rq;
  endfunction

  function automatic bit quiet_stretch();
    return (cyc % 40000) < 10000;
  endfunction

  // input side
  always @(posedge clk) begin
    request_t rq;
    cyc <= cyc + 1;
    if (rst_n) begin
      if (in_valid && !in_stall)
        replies_due.push_back(predict_reply('{in_operation, in_address_low, in_device_id_in}));
      if (!in_valid || !in_stall) begin
        if (pending.size() != 0 && (quiet_stretch() || $urandom_range(99) >= 17)) begin
          rq = pending.pop_front();
          issued++;
          in_operation <= rq.op;
          in_address_low <= rq.addr;
          in_device_id_in <= rq.id;
          in_valid <= 1;
        end else
          in_valid <= 0;
      end
    end
    if (cyc > CYCLE_LIMIT) begin
      $display("%0t timeout", $time);
      $display("Verification failed");
      $finish;
    end
  end

  // output side
  always @(posedge clk) begin
    reply_t e;
    if (rst_n) begin
      if (out_valid && !out_stall) begin
        if (replies_due.size() == 0) begin
          $display("%0t unexpected result word", $time);
          failed = 1;
        end else begin
          e = replies_due.pop_front();
          checked++;
          if (e.status !== out_status || e.found !== out_found ||
              e.addr !== out_address_out || e.id !== out_device_id_out ||
              e.count !== out_device_count) begin
            $display("%0t mismatch exp st=%0d fd=%0d a=%h id=%h n=%0d", $time,
                     e.status, e.found, e.addr, e.id, e.count);
            $display("%0t          got st=%0d fd=%0d a=%h id=%h n=%0d", $time,
                     out_status, out_found, out_address_out, out_device_id_out,
                     out_device_count);
            failed = 1;
          end
        end
      end
      out_stall <= !quiet_stretch() && $urandom_range(99) < 17;
    end
  end

  task automatic wait_idle();
    while (pending.size() != 0 || issued != checked) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_base(logic [31:0] v);
    wait_idle();
    cfg_psel <= 1;
    cfg_pwrite <= 1;
    cfg_paddr <= REG_BASE_LOW;
    cfg_pwdata <= v;
    @(posedge clk);
    cfg_penable <= 1;
    @(posedge clk);
    cfg_psel <= 0;
    cfg_penable <= 0;
    cfg_pwrite <= 0;
    base_reg = v;
    @(posedge clk);
  endtask

  task automatic add(logic [2:0] op, logic [31:0] a, logic [31:0] idv);
    pending.push_back('{op, a, idv});
  endtask

  initial begin
    logic [31:0] bases[5];
    int pct[5];
    int cnt[5];
    for (int i = 0; i < SLOTS; i++) begin
      occupied[i] = 0;
      slot_ident[i] = '0;
    end
    bases = '{32'h0a000000, 32'hffffff00, 32'h0, 32'hffffffff, 32'h12345600};
    pct = '{60, 85, 50, 30, 45};
    cnt = '{150, 350, 200, 150, 150};
    repeat (9) @(posedge clk);
    rst_n <= 1;
    @(posedge clk);
    write_base(bases[0]);
    // directed words
    add(OP_LOOKUP, slot_addr(5), 0);
    add(OP_RELEASE, slot_addr(5), 0);
    add(OP_NEXT_DEV, slot_addr(0), 0);
    add(OP_ASSIGN_STATIC, slot_addr(1), 0);
    add(OP_ASSIGN_STATIC, slot_addr(0), 0);
    add(OP_ASSIGN_STATIC, slot_addr(SLOTS - 1), 0);
    add(OP_RELEASE, slot_addr(1), 0);
    add(OP_ASSIGN_NEXT, 32'hffffffff, 32'hffffffff);
    add(OP_ASSIGN_NEXT, 32'h0, 0);
    add(OP_ASSIGN_STATIC, slot_addr(2), 0);
    add(OP_ASSIGN_STATIC, 32'hffffffff, 0);
    add(OP_RELEASE, slot_addr(1), 0);
    add(OP_RELEASE, slot_addr(3), 0);
    add(OP_ASSIGN_STATIC, slot_addr(3), 0);
    add(OP_ID_TO_ADDR, 0, 32'd1);
    add(OP_ID_TO_ADDR, 0, 32'hffffffff);
    add(OP_ID_TO_ADDR, 0, 32'd3);
    add(OP_LOOKUP, slot_addr(3), 0);
    add(OP_LOOKUP, 32'h0, 0);
    add(OP_NEXT_DEV, slot_addr(2), 0);
    add(OP_NEXT_DEV, slot_addr(SLOTS - 1), 0);
    add(OP_UNUSED_A, 32'hffffffff, 32'hffffffff);
    add(OP_UNUSED_B, 32'h0, 32'h0);
    for (int ph = 0; ph < 5; ph++) begin
      if (ph != 0) write_base(bases[ph] == 32'h0 ? 32'({$urandom, 8'h00}) & 32'hffffff00 :
                              bases[ph]);
      for (int k = 0; k < cnt[ph]; k++) pending.push_back(make_request(pct[ph]));
    end
    write_base(32'h0);
    for (int k = 0; k < 60; k++) pending.push_back(make_request(40));
    wait_idle();
    repeat (20) @(posedge clk);
    if (!failed)
      $display("Verification passed");
    else
      $display("Verification failed");
    $finish;
  end

endmodule
